// ===== src/page_table_presence_walk_assert.svh =====
// Assertion macros for the page table presence walker.
// Included by the modules that check their own logic; define ASSERT_OFF to drop them.
`ifndef PAGE_TABLE_PRESENCE_WALK_ASSERT_SVH
`define PAGE_TABLE_PRESENCE_WALK_ASSERT_SVH

`ifndef ASSERT_OFF
`define PTPW_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");
`define PTPW_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define PTPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define PTPW_ASSERT_ALWAYS(label, clk, rst, expr)
`define PTPW_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define PTPW_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/ptpw_pkg.sv =====
// Shared types and constants of the page table presence walker.
// No dependencies; used by ptpw_front, ptpw_queue and the top level.
package ptpw_pkg;

   localparam int unsigned ADDR_W  = 52;
   localparam int unsigned VADDR_W = 48;
   localparam int unsigned ENTRY_W = 64;
   localparam int unsigned PPN_W   = 36;

   // input kinds
   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_ENTRY  = 1'b1;

   // result kinds
   localparam logic RESULT_READ   = 1'b0;
   localparam logic RESULT_ANSWER = 1'b1;

   // page size codes
   localparam logic [1:0] SIZE_4K   = 2'd0;
   localparam logic [1:0] SIZE_2M   = 2'd1;
   localparam logic [1:0] SIZE_1G   = 2'd2;
   localparam logic [1:0] SIZE_NONE = 2'd3;

   // walk levels
   localparam logic [1:0] LEVEL_TOP    = 2'd0;
   localparam logic [1:0] LEVEL_SECOND = 2'd1;
   localparam logic [1:0] LEVEL_THIRD  = 2'd2;
   localparam logic [1:0] LEVEL_LAST   = 2'd3;

   localparam int unsigned BIT_PRESENT   = 0;
   localparam int unsigned BIT_PAGE_SIZE = 7;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = 1;
   localparam int unsigned QUEUE_CNT_W = 2;

   typedef struct packed {
      logic [1:0]        size_code;
      logic              mapped;
      logic [ADDR_W-1:0] read_addr;
      logic              result_kind;
   } result_type;

endpackage

// ===== src/ptpw_front.sv =====
// Front part of the walker: accepts request words, keeps the walk state
// and classifies each word into a read request, an answer or nothing. Uses ptpw_pkg.
`include "page_table_presence_walk_assert.svh"

module ptpw_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic                         req_kind,
   input  logic [ptpw_pkg::VADDR_W-1:0] req_virt_addr,
   input  logic [ptpw_pkg::ENTRY_W-1:0] req_entry_data,
   input  logic [ptpw_pkg::ADDR_W-1:0]  root_table_base,
   input  logic                         queue_full,
   output logic                         push,
   output ptpw_pkg::result_type         push_data
);

   logic [ptpw_pkg::PPN_W-1:0] ppn_ff, ppn_in;
   logic [1:0]                 level_ff, level_in;
   logic                       busy_ff, busy_in;
   logic                       accept;

   // entry address: table is 4K aligned and index*8 stays below 4K, so no add
   function automatic logic [ptpw_pkg::ADDR_W-1:0] entry_addr(
      input logic [ptpw_pkg::ADDR_W-1:0] table_base,
      input logic [ptpw_pkg::PPN_W-1:0]  ppn,
      input logic [1:0]                  level
   );
      logic [8:0] idx;
      case (level)
         ptpw_pkg::LEVEL_TOP:    idx = ppn[35:27];
         ptpw_pkg::LEVEL_SECOND: idx = ppn[26:18];
         ptpw_pkg::LEVEL_THIRD:  idx = ppn[17:9];
         ptpw_pkg::LEVEL_LAST:   idx = ppn[8:0];
         default:                idx = ppn[8:0];
      endcase
      return {table_base[ptpw_pkg::ADDR_W-1:12], idx, 3'b000};
   endfunction

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      ppn_in    = ppn_ff;
      level_in  = level_ff;
      busy_in   = busy_ff;
      push      = 1'b0;
      push_data = '0;
      if (accept) begin
         if (req_kind == ptpw_pkg::KIND_LOOKUP) begin
            // restart the walk from the top table
            ppn_in                = req_virt_addr[ptpw_pkg::VADDR_W-1:12];
            level_in              = ptpw_pkg::LEVEL_TOP;
            busy_in               = 1'b1;
            push                  = 1'b1;
            push_data.result_kind = ptpw_pkg::RESULT_READ;
            push_data.read_addr   = entry_addr(root_table_base,
                                               req_virt_addr[ptpw_pkg::VADDR_W-1:12],
                                               ptpw_pkg::LEVEL_TOP);
         end else if (busy_ff) begin
            push = 1'b1;
            if (!req_entry_data[ptpw_pkg::BIT_PRESENT]) begin
               push_data.result_kind = ptpw_pkg::RESULT_ANSWER;
               push_data.mapped      = 1'b0;
               push_data.size_code   = ptpw_pkg::SIZE_NONE;
            end else if (level_ff == ptpw_pkg::LEVEL_SECOND &&
                         req_entry_data[ptpw_pkg::BIT_PAGE_SIZE]) begin
               push_data.result_kind = ptpw_pkg::RESULT_ANSWER;
               push_data.mapped      = 1'b1;
               push_data.size_code   = ptpw_pkg::SIZE_1G;
            end else if (level_ff == ptpw_pkg::LEVEL_THIRD &&
                         req_entry_data[ptpw_pkg::BIT_PAGE_SIZE]) begin
               push_data.result_kind = ptpw_pkg::RESULT_ANSWER;
               push_data.mapped      = 1'b1;
               push_data.size_code   = ptpw_pkg::SIZE_2M;
            end else if (level_ff == ptpw_pkg::LEVEL_LAST) begin
               push_data.result_kind = ptpw_pkg::RESULT_ANSWER;
               push_data.mapped      = 1'b1;
               push_data.size_code   = ptpw_pkg::SIZE_4K;
            end else begin
               // descend one level
               level_in              = level_ff + 2'd1;
               push_data.result_kind = ptpw_pkg::RESULT_READ;
               push_data.read_addr   = entry_addr(req_entry_data[ptpw_pkg::ADDR_W-1:0],
                                                  ppn_ff, level_ff + 2'd1);
            end
            if (push_data.result_kind == ptpw_pkg::RESULT_ANSWER) begin
               busy_in  = 1'b0;
               level_in = ptpw_pkg::LEVEL_TOP;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ppn_ff   <= '0;
         level_ff <= ptpw_pkg::LEVEL_TOP;
         busy_ff  <= 1'b0;
      end else begin
         ppn_ff   <= ppn_in;
         level_ff <= level_in;
         busy_ff  <= busy_in;
      end
   end

   `PTPW_ASSERT_NEXT(a_answer_ends_walk, clock, reset,
      push && push_data.result_kind == ptpw_pkg::RESULT_ANSWER, !busy_ff)
   `PTPW_ASSERT_NEXT(a_lookup_starts_walk, clock, reset,
      accept && req_kind == ptpw_pkg::KIND_LOOKUP,
      busy_ff && level_ff == ptpw_pkg::LEVEL_TOP)
   `PTPW_ASSERT_IMPLIES(a_idle_at_top, clock, reset,
      !busy_ff, level_ff == ptpw_pkg::LEVEL_TOP)

endmodule

// ===== src/ptpw_queue.sv =====
// Back part of the walker: a two-entry queue of result words that drives
// the result channel and lets the front run while the receiver stalls. Uses ptpw_pkg.
`include "page_table_presence_walk_assert.svh"

module ptpw_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ptpw_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ptpw_pkg::result_type out_data
);

   ptpw_pkg::result_type mem [ptpw_pkg::QUEUE_DEPTH];

   logic [ptpw_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ptpw_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ptpw_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                             pop;

   assign full      = count_ff == ptpw_pkg::QUEUE_CNT_W'(ptpw_pkg::QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign pop       = out_valid && out_ready;
   assign out_data  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `PTPW_ASSERT_ALWAYS(a_count_bound, clock, reset,
      count_ff <= ptpw_pkg::QUEUE_CNT_W'(ptpw_pkg::QUEUE_DEPTH))
   `PTPW_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push, !full)
   `PTPW_ASSERT_ALWAYS(a_ptr_gap, clock, reset,
      (wr_ptr_ff == rd_ptr_ff) == (count_ff == '0 || full))

endmodule

// ===== src/page_table_presence_walk.sv =====
// Top level of the four-level page table presence walker.
// Holds the table base register and joins ptpw_front and ptpw_queue. Uses ptpw_pkg.
//
// Channels:
//   req_*  : one word per cycle while req_tready is high; tuser selects a lookup
//            (0, virtual address in tdata[47:0]) or a returned table entry (1, entry in tdata[111:48]).
//   rsp_*  : read requests (tuser 0, address in tdata[51:0]) and final answers
//            (tuser 1, mapped in tdata[52], page size in tdata[54:53]).
//   csr_*  : write of the table base; taken at once, bits 11..0 ignored.
// Each request word is classified in the cycle it is accepted; its result
// word is written into a two-entry queue and offered on rsp_* from there.
// Throughput is one word per cycle while the queue is not full, set by the single
// classify stage in the front. A table entry that arrives with no walk in
// progress yields no result; a lookup during a walk abandons that walk.
// Reset clears the walk state, the queue and the table base. When the
// receiver stalls, up to two result words wait in the queue and req_tready
// drops only once both entries are taken.
module page_table_presence_walk (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [111:0]  req_tdata,   // virt_addr[47:0], entry_data[111:48]
   input  logic          req_tuser,   // kind[0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata,   // read_addr[51:0], mapped[52], size_code[54:53], zero[55]
   output logic          rsp_tuser,   // result_kind[0]
   input  logic          csr_valid,
   output logic          csr_ready,
   input  logic [51:0]   csr_data
);

   logic [ptpw_pkg::ADDR_W-1:0] root_ff, root_in;
   logic                        queue_full;
   logic                        push;
   ptpw_pkg::result_type        push_data;
   ptpw_pkg::result_type        out_data;

   assign csr_ready = 1'b1;
   assign root_in   = (csr_valid && csr_ready) ? csr_data : root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff <= '0;
      end else begin
         root_ff <= root_in;
      end
   end

   ptpw_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_kind        (req_tuser),
      .req_virt_addr   (req_tdata[47:0]),
      .req_entry_data  (req_tdata[111:48]),
      .root_table_base (root_ff),
      .queue_full      (queue_full),
      .push            (push),
      .push_data       (push_data)
   );

   ptpw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   assign rsp_tuser = out_data.result_kind;
   assign rsp_tdata = {1'b0, out_data.size_code, out_data.mapped, out_data.read_addr};

endmodule
